// ===== sv/lnr_pkg.sv =====
`timescale 1ns / 1ps

package lnr_pkg;

  localparam int SYM_BITS  = 8;
  localparam int OUT_BITS  = 32;
  localparam int NUM_BITS  = 5;

  localparam logic [SYM_BITS-1:0] SYM_N_UPPER = 8'h4E;  // 'N'
  localparam logic [SYM_BITS-1:0] SYM_N_LOWER = 8'h6E;  // 'n'

  localparam logic [NUM_BITS-1:0] NUM_TOP_RESET = 5'd1;

  // per-cycle command shared by every cell of the chain
  typedef struct packed {
    logic ins;    // insert the new run at its sorted place
    logic shift;  // move every entry one cell toward the head
    logic clear;  // drop all entries
  } cell_ctl_t;

endpackage

// ===== sv/lnr_cell.sv =====
`timescale 1ns / 1ps

module lnr_cell #(
  parameter int POS_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  lnr_pkg::cell_ctl_t  ctl,
  // new run, same for all cells
  input  logic [POS_BITS-1:0] new_start,
  input  logic [POS_BITS-1:0] new_end,
  input  logic [POS_BITS-1:0] new_len,
  // neighbor toward the head
  input  logic                prev_keep,
  input  logic                prev_valid,
  input  logic [POS_BITS-1:0] prev_start,
  input  logic [POS_BITS-1:0] prev_end,
  input  logic [POS_BITS-1:0] prev_len,
  // neighbor toward the tail
  input  logic                next_valid,
  input  logic [POS_BITS-1:0] next_start,
  input  logic [POS_BITS-1:0] next_end,
  input  logic [POS_BITS-1:0] next_len,
  // own entry
  output logic                keep,
  output logic                valid,
  output logic [POS_BITS-1:0] start,
  output logic [POS_BITS-1:0] stop,
  output logic [POS_BITS-1:0] len
);

  // an entry at least as long as the new run stays put (ties keep arrival order)
  assign keep = valid && (len >= new_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      if (!keep) begin
        valid <= prev_keep ? 1'b1 : prev_valid;
      end
    end else if (ctl.shift) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && !keep) begin
      if (prev_keep) begin
        start <= new_start;
        stop  <= new_end;
        len   <= new_len;
      end else begin
        start <= prev_start;
        stop  <= prev_end;
        len   <= prev_len;
      end
    end else if (ctl.shift) begin
      start <= next_start;
      stop  <= next_end;
      len   <= next_len;
    end
  end

endmodule

// ===== sv/longest_n_run_top_k_unit.sv =====
`timescale 1ns / 1ps

// Longest N-run finder. Characters arrive one per beat on the s_ side with
// tlast on the final character of a sequence; every maximal run of 'N'/'n'
// becomes a half-open interval [start, end), a run open at the end closing at
// the sequence length. Closed runs are sorted into a chain of TOP_K cells,
// longest first, equal lengths in order of appearance; a run no longer than
// every entry of a full chain is dropped. The chain inserts in the same
// cycle, so a sequence streams at one character per cycle. After the tlast
// beat the input stalls while the chain shifts its entries out through the
// head cell: min(num_top, TOP_K, runs found) result beats on the m_ side,
// last one flagged by m_tlast, each held while m_tready is low, then a closing
// step clears the chain; a sequence without runs gives no beats. num_top (cfg
// channel, always ready; reset value 1) is kept across sequences; the user must
// write it only while idle, not enforced by the block. Positions wrap modulo
// 2^POS_BITS; reported positions are cut or zero-extended to 32 bits.

module longest_n_run_top_k_unit #(
  parameter int TOP_K    = 16,
  parameter int POS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // character stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,   // last_symbol
  // run stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] run_start, [63:32] run_end
  output logic        m_tlast,   // last_run
  // num_top register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data   // num_top
);

  localparam int RW = $clog2(TOP_K + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state;

  logic [lnr_pkg::NUM_BITS-1:0] num_top;
  logic [POS_BITS-1:0]          position;
  logic                         in_run;
  logic [POS_BITS-1:0]          open_run_start;
  logic [RW-1:0]                remaining;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_top <= lnr_pkg::NUM_TOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_top <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- scan
  logic                s_beat;
  logic                is_n;
  logic [POS_BITS-1:0] pos_inc;
  logic [POS_BITS-1:0] ins_start;
  logic [POS_BITS-1:0] ins_end;
  logic [POS_BITS-1:0] ins_len;
  logic [RW-1:0]       want;

  assign s_tready = (state == ST_IDLE);
  assign s_beat   = s_tvalid && s_tready;
  assign is_n     = (s_tdata == lnr_pkg::SYM_N_UPPER) ||
                    (s_tdata == lnr_pkg::SYM_N_LOWER);
  assign pos_inc  = position + POS_BITS'(1);

  // a run closes on a non-N after a run, or on an N that ends the sequence
  assign ins_start = in_run ? open_run_start : position;
  assign ins_end   = is_n ? pos_inc : position;
  assign ins_len   = ins_end - ins_start;

  // beats to report, saturated at the chain depth
  assign want = (int'(num_top) > TOP_K) ? RW'(TOP_K) : RW'(num_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      in_run   <= 1'b0;
    end else if (s_beat) begin
      position <= s_tlast ? '0 : pos_inc;
      in_run   <= s_tlast ? 1'b0 : is_n;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat && is_n && !in_run) begin
      open_run_start <= position;
    end
  end

  // ---------------------------------------------------------------- chain
  // index 0 carries the new run; cell i sits at index i+1; the tail slot is empty
  logic [TOP_K+1:0]    c_valid;
  logic [TOP_K:0]      c_keep;
  logic [POS_BITS-1:0] c_start [TOP_K+2];
  logic [POS_BITS-1:0] c_end   [TOP_K+2];
  logic [POS_BITS-1:0] c_len   [TOP_K+2];

  lnr_pkg::cell_ctl_t ctl;

  assign c_keep[0]        = 1'b1;
  assign c_valid[0]       = 1'b1;
  assign c_start[0]       = ins_start;
  assign c_end[0]         = ins_end;
  assign c_len[0]         = ins_len;
  assign c_valid[TOP_K+1] = 1'b0;
  assign c_start[TOP_K+1] = '0;
  assign c_end[TOP_K+1]   = '0;
  assign c_len[TOP_K+1]   = '0;

  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    lnr_cell #(
      .POS_BITS (POS_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_start  (ins_start),
      .new_end    (ins_end),
      .new_len    (ins_len),
      .prev_keep  (c_keep[i]),
      .prev_valid (c_valid[i]),
      .prev_start (c_start[i]),
      .prev_end   (c_end[i]),
      .prev_len   (c_len[i]),
      .next_valid (c_valid[i+2]),
      .next_start (c_start[i+2]),
      .next_end   (c_end[i+2]),
      .next_len   (c_len[i+2]),
      .keep       (c_keep[i+1]),
      .valid      (c_valid[i+1]),
      .start      (c_start[i+1]),
      .stop       (c_end[i+1]),
      .len        (c_len[i+1])
    );
  end

  // ---------------------------------------------------------------- drain
  logic out_free;
  logic drain_done;
  logic pop;

  assign out_free   = !m_tvalid || m_tready;
  assign drain_done = (remaining == '0) || !c_valid[1];
  assign pop        = (state == ST_DRAIN) && !drain_done && out_free;

  always_comb begin
    ctl.ins   = s_beat && ((!is_n && in_run) || (is_n && s_tlast));
    ctl.shift = pop;
    ctl.clear = (state == ST_DRAIN) && drain_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      remaining <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_beat && s_tlast) begin
            state     <= ST_DRAIN;
            remaining <= want;
          end
        end
        ST_DRAIN: begin
          if (drain_done) begin
            state <= ST_IDLE;
          end else if (pop) begin
            remaining <= remaining - RW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata[31:0]  <= lnr_pkg::OUT_BITS'(c_start[1]);
      m_tdata[63:32] <= lnr_pkg::OUT_BITS'(c_end[1]);
      m_tlast        <= (remaining == RW'(1)) || !c_valid[2];
    end
  end

endmodule

// ===== sv/lnr_checker.sv =====
`timescale 1ns / 1ps

module lnr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [4:0]  cfg_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // end of sequence stops the input for the report
  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input not stalled after final character");

  // the input only stalls because a sequence ended
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("input stalled without a final character");

  // new results are only produced while the input is stalled
  a_out_in_report: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result beat outside report phase");

endmodule

bind longest_n_run_top_k_unit lnr_checker u_lnr_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int TOP_K        = 16;
  localparam int POS_BITS     = 32;
  localparam int HOLD_CYCLES  = 300;     // long m_tready hold-off, pressure phase
  localparam int PRESS_PHASE  = 4;
  localparam int PHASE_CHARS  = 8;       // minimum characters per plain phase
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;       // settle wait after the last run, for the unit's closing step
  localparam int DIR_ROWS     = 28;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum logic [1:0] {SEQ_RUNS, SEQ_FULL, SEQ_NOISE, SEQ_ALL_N} seq_style_t;
  typedef enum logic {ROW_SYM, ROW_NUM_TOP} row_kind_t;
  // how a directed row is checked: by the tracker, against typed values, or not at all
  typedef enum logic [1:0] {CHK_TRACK, CHK_NONE, CHK_ONE} row_chk_t;

  typedef struct packed {
    logic [31:0] run_start;
    logic [31:0] run_end;
    logic        run_last;
  } run_beat_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  sym;
    logic        is_last;
    row_chk_t    chk;
    logic [4:0]  num_top;
    logic [31:0] exp_start;
    logic [31:0] exp_end;
  } dir_row_t;

  // ---------------------------------------------------------------- DUT I/O
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] symbol
  logic        s_tlast = 1'b0;   // last_symbol
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;          // [31:0] run_start, [63:32] run_end
  logic        m_tlast;          // last_run
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;    // num_top

  longest_n_run_top_k_unit #(
    .TOP_K    (TOP_K),
    .POS_BITS (POS_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ------------------------------------------------------------ run tracker
  // Mirror of the unit's sequence state: position counter, the open run and
  // the sorted table of longest closed runs (longest first, ties by age).
  logic [4:0]  num_top_q = lnr_pkg::NUM_TOP_RESET;
  logic [31:0] seq_pos = '0;
  logic        in_run = 1'b0;
  logic [31:0] open_start = '0;
  logic [31:0] best_start [TOP_K];
  logic [31:0] best_end [TOP_K];
  int          best_cnt = 0;

  run_beat_t   expected_runs [$];

  // Sorted insert: a new run lands behind every stored run at least as
  // long; on a full table the shortest falls off, or the new one is dropped.
  function automatic void file_run(logic [31:0] s, logic [31:0] e);
    logic [31:0] len;
    int slot;
    int i;
    len = e - s;
    slot = 0;
    while (slot < best_cnt && (best_end[slot] - best_start[slot]) >= len) slot++;
    if (slot >= TOP_K) return;
    i = (best_cnt < TOP_K) ? best_cnt : TOP_K - 1;
    while (i > slot) begin
      best_start[i] = best_start[i-1];
      best_end[i]   = best_end[i-1];
      i--;
    end
    best_start[slot] = s;
    best_end[slot]   = e;
    if (best_cnt < TOP_K) best_cnt++;
  endfunction

  // Advance the tracker by one character; on the final one, queue the runs
  // to report (unless the caller types them in) and clear the sequence.
  function automatic void track_symbol(logic [7:0] sym, logic is_last, logic push);
    int want;
    int n_out;
    run_beat_t rb;
    if (sym == lnr_pkg::SYM_N_UPPER || sym == lnr_pkg::SYM_N_LOWER) begin
      if (!in_run) begin
        open_start = seq_pos;
        in_run = 1'b1;
      end
    end else if (in_run) begin
      file_run(open_start, seq_pos);
      in_run = 1'b0;
    end
    seq_pos = seq_pos + 32'd1;
    if (!is_last) return;
    // run open at the end closes at the sequence length
    if (in_run) file_run(open_start, seq_pos);
    want  = (int'(num_top_q) > TOP_K) ? TOP_K : int'(num_top_q);
    n_out = (want < best_cnt) ? want : best_cnt;
    if (push) begin
      for (int k = 0; k < n_out; k++) begin
        rb.run_start = best_start[k];
        rb.run_end   = best_end[k];
        rb.run_last  = (k == n_out - 1);
        expected_runs = {expected_runs, rb};
      end
    end
    seq_pos = '0;
    in_run = 1'b0;
    open_start = '0;
    best_cnt = 0;
  endfunction

  // ------------------------------------------------------- shared run state
  idle_mode_t idle_mode = IDLE_NONE;
  int         phase_no = -1;         // -1 while the directed table runs
  int         fail_cnt = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  int         cycle_cnt = 0;
  run_beat_t  got_run;
  run_beat_t  exp_run;

  function automatic int sender_pct();
    return (idle_mode == IDLE_SEND) ? 82 : (idle_mode == IDLE_BOTH) ? 28 : 0;
  endfunction

  function automatic int recv_pct();
    return (idle_mode == IDLE_RECV) ? 82 : (idle_mode == IDLE_BOTH) ? 28 : 0;
  endfunction

  // Receiver: random stalls per idle mode, plus one long hold-off at the
  // start of the pressure phase so the unit backs up and stalls s_tready.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 1'b0;
    end else if (phase_no == PRESS_PHASE && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(0, 99) >= recv_pct());
    end
  end

  // Result monitor: each run beat against the oldest queued run.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_run.run_start = m_tdata[31:0];
      got_run.run_end   = m_tdata[63:32];
      got_run.run_last  = m_tlast;
      if (expected_runs.size() == 0) begin
        $error("unexpected run beat: run_start %0d run_end %0d last_run %0b",
               got_run.run_start, got_run.run_end, got_run.run_last);
        fail_cnt++;
      end else begin
        exp_run = expected_runs.pop_front();
        if (got_run.run_start !== exp_run.run_start) begin
          $error("run_start: expected %0d, got %0d", exp_run.run_start, got_run.run_start);
          fail_cnt++;
        end
        if (got_run.run_end !== exp_run.run_end) begin
          $error("run_end: expected %0d, got %0d", exp_run.run_end, got_run.run_end);
          fail_cnt++;
        end
        if (got_run.run_last !== exp_run.run_last) begin
          $error("last_run: expected %0b, got %0b", exp_run.run_last, got_run.run_last);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------ stimulus
  // One character beat: optional idle gap, then hold it until accepted.
  task automatic send_char(logic [7:0] sym, logic is_last, logic push);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_pct()) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = sym;
    s_tlast  = is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_symbol(sym, is_last, push);
  endtask

  // Stop offering, wait for every queued run, then let the unit settle
  // (sequences without runs still pass through a closing step inside the unit).
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_num_top(logic [4:0] val);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    num_top_q = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] n_byte();
    return $urandom_range(0, 1) ? lnr_pkg::SYM_N_UPPER : lnr_pkg::SYM_N_LOWER;
  endfunction

  function automatic logic [7:0] other_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == lnr_pkg::SYM_N_UPPER || b == lnr_pkg::SYM_N_LOWER)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic seq_style_t pick_style();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return SEQ_RUNS;
    if (r < 13) return SEQ_FULL;
    if (r < 18) return SEQ_NOISE;
    return SEQ_ALL_N;
  endfunction

  // Build one sequence of the given shape and stream it; returns its length.
  task automatic send_sequence(seq_style_t style, output int n_chars);
    logic [7:0] chars [$];
    int nruns;
    unique case (style)
      SEQ_RUNS: begin
        // well formed: gaps and runs of random size, maybe open at the end
        repeat ($urandom_range(0, 2)) chars = {chars, other_byte()};
        nruns = $urandom_range(0, 5);
        for (int r = 0; r < nruns; r++) begin
          repeat ($urandom_range(1, 6)) chars = {chars, n_byte()};
          if (r < nruns - 1) repeat ($urandom_range(1, 3)) chars = {chars, other_byte()};
        end
        repeat ($urandom_range(0, 2)) chars = {chars, other_byte()};
      end
      SEQ_FULL: begin
        // more short runs than the table holds: ties, drops, evictions
        nruns = $urandom_range(TOP_K + 1, TOP_K + 4);
        for (int r = 0; r < nruns; r++) begin
          repeat ($urandom_range(1, 2)) chars = {chars, n_byte()};
          chars = {chars, other_byte()};
        end
      end
      SEQ_NOISE: begin
        repeat ($urandom_range(1, 12))
          chars = {chars,
                   (($urandom_range(0, 2) == 0) ? n_byte() : 8'($urandom_range(0, 255)))};
      end
      default: begin
        repeat ($urandom_range(1, 6)) chars = {chars, n_byte()};
      end
    endcase
    if (chars.size() == 0) chars = {chars, other_byte()};
    n_chars = chars.size();
    for (int i = 0; i < n_chars; i++) send_char(chars[i], i == n_chars - 1, 1'b1);
  endtask

  // Directed table: single-char sequences, no runs, field extremes (0x00
  // and 0xFF), num_top zero, num_top above TOP_K, equal-length ordering,
  // fewer runs than num_top, and a run left open at the end.
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b1, CHK_ONE,   5'd0,  32'd0, 32'd1},
    '{ROW_SYM, "A",                  1'b1, CHK_NONE,  5'd0,  32'd0, 32'd0},
    '{ROW_SYM, 8'h00,                1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_LOWER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_LOWER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, 8'hFF,                1'b1, CHK_ONE,   5'd0,  32'd1, 32'd3},
    '{ROW_NUM_TOP, 8'h00,            1'b0, CHK_NONE,  5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b1, CHK_NONE,  5'd0,  32'd0, 32'd0},
    '{ROW_NUM_TOP, 8'h00,            1'b0, CHK_NONE,  5'd31, 32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, "x",                  1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_LOWER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, "z",                  1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b1, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_NUM_TOP, 8'h00,            1'b0, CHK_NONE,  5'd16, 32'd0, 32'd0},
    '{ROW_SYM, "M",                  1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, "O",                  1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_LOWER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_LOWER, 1'b1, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_NUM_TOP, 8'h00,            1'b0, CHK_NONE,  5'd2,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, "a",                  1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b0, CHK_TRACK, 5'd0,  32'd0, 32'd0},
    '{ROW_SYM, lnr_pkg::SYM_N_UPPER, 1'b1, CHK_TRACK, 5'd0,  32'd0, 32'd0}
  };

  initial begin
    int phase_items;
    int n_chars;
    int ph;
    run_beat_t typed;

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed part, no idling
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_NUM_TOP) begin
        write_num_top(dir_table[i].num_top);
      end else begin
        send_char(dir_table[i].sym, dir_table[i].is_last, dir_table[i].chk == CHK_TRACK);
        if (dir_table[i].chk == CHK_ONE) begin
          typed.run_start = dir_table[i].exp_start;
          typed.run_end   = dir_table[i].exp_end;
          typed.run_last  = 1'b1;
          expected_runs = {expected_runs, typed};
        end
      end
    end

    // Random part: phases cycle through the idle modes with a fresh num_top
    // each; the pressure phase runs a full table against a held receiver.
    ph = 0;
    while (ph <= PRESS_PHASE) begin
      if (ph == PRESS_PHASE)
        write_num_top(5'(TOP_K));
      else if ($urandom_range(0, 9) == 0)
        write_num_top(5'($urandom_range(TOP_K + 1, 31)));
      else
        write_num_top(5'($urandom_range(1, TOP_K)));
      idle_mode = (ph == PRESS_PHASE) ? IDLE_NONE : idle_mode_t'(ph % 4);
      phase_no = ph;
      phase_items = 0;
      if (ph == PRESS_PHASE) begin
        send_sequence(SEQ_FULL, n_chars);
        phase_items += n_chars;
      end
      while (phase_items < PHASE_CHARS) begin
        send_sequence(pick_style(), n_chars);
        phase_items += n_chars;
      end
      ph++;
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
